FILE: hw/rtl/lpd_pkg.sv
// Package for the length-prefixed deframer: header geometry, result status
// codes and register map constants. No dependencies.

package lpd_pkg;

   // Frame header: 32-bit LE length, then 16-bit LE type
   localparam int HEADER_BYTES = 6;
   localparam int LEN_BYTES    = 4;
   localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);

   localparam logic [HDR_CNT_W-1:0] HDR_CNT_TYPE_LO = HDR_CNT_W'(LEN_BYTES);
   localparam logic [HDR_CNT_W-1:0] HDR_CNT_TYPE_HI = HDR_CNT_W'(HEADER_BYTES - 1);

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 32;
   localparam int TYPE_W   = 16;
   localparam int STATUS_W = 2;

   localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_PAYLOAD = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_ERROR   = 2'd2
   } lpd_status_type;

   // Register map: 32-bit words, with a single register (max_payload) at word 0
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_PAYLOAD = 1'b0
   } lpd_csr_idx_type;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 32'd16777216;

endpackage

FILE: hw/rtl/lpd_if.sv
// Stream channel interfaces of the deframer: byte request and result beats.
// Depends on lpd_pkg for field widths.

interface lpd_req_if
   import lpd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpd_rsp_if
   import lpd_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   payload_byte;
   logic [TYPE_W-1:0]   frame_type;
   logic                last_of_frame;

   modport source (output valid, output status, output payload_byte,
                   output frame_type, output last_of_frame, input ready);
   modport sink   (input valid, input status, input payload_byte,
                   input frame_type, input last_of_frame, output ready);
endinterface

FILE: hw/rtl/lpd_csr.sv
// APB-style register block of the deframer: holds max_payload.
// Depends on lpd_pkg for the register map.

module lpd_csr
   import lpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [LEN_W-1:0]      max_payload
);

   logic [LEN_W-1:0]     max_payload_ff;
   logic [LEN_W-1:0]     max_payload_in;
   lpd_csr_idx_type      reg_idx;
   logic                 wr_strobe;

   assign reg_idx    = lpd_csr_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      max_payload_in = max_payload_ff;
      csr_prdata     = '0;
      unique case (reg_idx)
         CSR_MAX_PAYLOAD: begin
            csr_prdata = max_payload_ff;
            if (wr_strobe) begin
               max_payload_in = csr_pwdata;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   assign max_payload = max_payload_ff;

endmodule

FILE: hw/rtl/length_prefixed_deframer.sv
// Top level of the length-prefixed deframer: header parser and result register.
// Depends on lpd_pkg, lpd_if.sv (lpd_req_if, lpd_rsp_if) and lpd_csr.
//
//   channel  dir  beat
//   req      in   one stream byte (data_byte)
//   rsp      out  status, payload_byte, frame_type, last_of_frame
//   csr      in   APB-style write/read of max_payload
//
// One byte is taken per clock while req.ready is high; any result is registered in the
// output register at the same edge that accepts its byte.
// A result waiting in the output register blocks req until rsp takes it:
// req.ready is high whenever that register is empty or is being drained this cycle.
// Reset (synchronous) clears all parser state and the output valid; after an
// oversize length the parser drops every byte until the next reset.

module length_prefixed_deframer
   import lpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lpd_req_if.sink               req,
   lpd_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LEN_W-1:0] max_payload;

   lpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_payload (max_payload)
   );

   // Parser state
   logic [HDR_CNT_W-1:0] header_count_ff, header_count_in;
   logic [LEN_W-1:0]     length_value_ff, length_value_in;
   logic [TYPE_W-1:0]    type_value_ff, type_value_in;
   logic [LEN_W-1:0]     bytes_remaining_ff, bytes_remaining_in;
   logic                 in_payload_ff, in_payload_in;
   logic                 poisoned_ff, poisoned_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   lpd_status_type       rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic [TYPE_W-1:0]    rsp_type_ff, rsp_type_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic                 has_result;
   logic [BYTE_W-1:0]    din;
   logic [TYPE_W-1:0]    full_type;

   // Take a beat whenever the result slot is free or draining now
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign din       = req.data_byte & BYTE_MASK;
   assign full_type = {din, type_value_ff[BYTE_W-1:0]};

   always_comb begin
      header_count_in    = header_count_ff;
      length_value_in    = length_value_ff;
      type_value_in      = type_value_ff;
      bytes_remaining_in = bytes_remaining_ff;
      in_payload_in      = in_payload_ff;
      poisoned_in        = poisoned_ff;
      has_result         = 1'b0;
      rsp_status_in      = STATUS_PAYLOAD;
      rsp_byte_in        = '0;
      rsp_type_in        = type_value_ff;
      rsp_last_in        = 1'b0;

      if (accept && !poisoned_ff) begin
         if (in_payload_ff) begin
            // cut-through payload byte
            has_result  = 1'b1;
            rsp_byte_in = din;
            if (bytes_remaining_ff <= LEN_W'(1)) begin
               rsp_last_in        = 1'b1;
               bytes_remaining_in = '0;
               in_payload_in      = 1'b0;
               header_count_in    = '0;
            end else begin
               bytes_remaining_in = bytes_remaining_ff - LEN_W'(1);
            end
         end else if (header_count_ff < HDR_CNT_TYPE_LO) begin
            // length bytes, little-endian; first one clears the rest
            if (header_count_ff == '0) begin
               length_value_in = {{(LEN_W-BYTE_W){1'b0}}, din};
            end else begin
               length_value_in[{header_count_ff[1:0], 3'b000} +: BYTE_W] = din;
            end
            header_count_in = header_count_ff + HDR_CNT_W'(1);
         end else if (header_count_ff < HDR_CNT_TYPE_HI) begin
            type_value_in   = {{(TYPE_W-BYTE_W){1'b0}}, din};
            header_count_in = header_count_ff + HDR_CNT_W'(1);
         end else begin
            // final header byte (any count past the end counts as final)
            type_value_in   = full_type;
            header_count_in = '0;
            rsp_type_in     = full_type;
            if (length_value_ff > max_payload) begin
               poisoned_in   = 1'b1;
               has_result    = 1'b1;
               rsp_status_in = STATUS_ERROR;
            end else if (length_value_ff == '0) begin
               has_result    = 1'b1;
               rsp_status_in = STATUS_EMPTY;
               rsp_last_in   = 1'b1;
            end else begin
               bytes_remaining_in = length_value_ff;
               in_payload_in      = 1'b1;
            end
         end
      end

      if (accept) begin
         rsp_valid_in = has_result;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff    <= '0;
         length_value_ff    <= '0;
         type_value_ff      <= '0;
         bytes_remaining_ff <= '0;
         in_payload_ff      <= 1'b0;
         poisoned_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         header_count_ff    <= header_count_in;
         length_value_ff    <= length_value_in;
         type_value_ff      <= type_value_in;
         bytes_remaining_ff <= bytes_remaining_in;
         in_payload_ff      <= in_payload_in;
         poisoned_ff        <= poisoned_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Result payload: loaded only with a new result
   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         rsp_status_ff <= rsp_status_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_type_ff   <= rsp_type_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.payload_byte  = rsp_byte_ff;
   assign rsp.frame_type    = rsp_type_ff;
   assign rsp.last_of_frame = rsp_last_ff;

`ifndef SYNTHESIS
   // poison is sticky until reset
   a_poison_sticky: assert property (@(posedge clock) disable iff (reset)
      poisoned_ff |=> poisoned_ff)
      else $error("poisoned flag dropped without reset");

   // inside a payload there is always at least one byte to come
   a_remaining_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (bytes_remaining_ff != '0))
      else $error("in payload with zero bytes remaining");

   // error beat carries no byte and no last mark
   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_ERROR)) |->
         (!rsp_last_ff && (rsp_byte_ff == '0)))
      else $error("error beat with payload or last mark");

   // a poisoned parser never raises a new result
   a_poison_silent: assert property (@(posedge clock) disable iff (reset)
      poisoned_ff |-> !(accept && has_result))
      else $error("result produced after poison");
`endif

endmodule

FILE: dv/lpd_deframe_checker.sv
// Checker for the length-prefixed deframer: watches byte, result and CSR traffic,
// predicts every result beat and compares it field by field.
// Depends on lpd_pkg and the channel interfaces in lpd_if.sv.
`timescale 1ns / 100ps

module lpd_deframe_checker
   import lpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lpd_req_if                    req_mon,
   lpd_rsp_if                    rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int unsigned           fail_count,
   output int unsigned           pending_count,
   output int unsigned           payload_count,
   output int unsigned           empty_count,
   output int unsigned           error_count
);

   typedef struct packed {
      lpd_status_type    status;
      logic [BYTE_W-1:0] payload_byte;
      logic [TYPE_W-1:0] frame_type;
      logic              last_of_frame;
   } deframed_beat_type;

   deframed_beat_type expected_beats[$];

   // shadow of the parser and of max_payload
   logic [HDR_CNT_W-1:0] hdr_count;
   logic [LEN_W-1:0]     len_acc;
   logic [TYPE_W-1:0]    type_acc;
   logic [LEN_W-1:0]     bytes_left;
   logic                 in_payload;
   logic                 poisoned;
   logic [LEN_W-1:0]     max_payload_reg;

   task automatic push_beat(input lpd_status_type status, input logic [BYTE_W-1:0] data,
                            input logic last);
      deframed_beat_type beat;
      beat.status        = status;
      beat.payload_byte  = data;
      beat.frame_type    = type_acc;
      beat.last_of_frame = last;
      expected_beats.insert(expected_beats.size(), beat);
   endtask

   task automatic deframe_byte(input logic [BYTE_W-1:0] data);
      logic last;
      if (poisoned)
         return;
      if (in_payload) begin
         last = (bytes_left <= 1);
         push_beat(STATUS_PAYLOAD, data, last);
         if (last) begin
            bytes_left = '0;
            in_payload = 1'b0;
            hdr_count  = '0;
         end else begin
            bytes_left = bytes_left - 1;
         end
         return;
      end
      if (hdr_count < LEN_BYTES) begin
         if (hdr_count == 0)
            len_acc = '0;
         len_acc   = len_acc | (LEN_W'(data) << (8 * hdr_count));
         hdr_count = hdr_count + 1'b1;
         return;
      end
      if (hdr_count < HEADER_BYTES - 1) begin
         type_acc  = {8'h00, data};
         hdr_count = hdr_count + 1'b1;
         return;
      end
      // last header byte: length is judged against max_payload as it stands now
      type_acc  = {data, type_acc[7:0]};
      hdr_count = '0;
      if (len_acc > max_payload_reg) begin
         poisoned = 1'b1;
         push_beat(STATUS_ERROR, '0, 1'b0);
      end else if (len_acc == 0) begin
         push_beat(STATUS_EMPTY, '0, 1'b1);
      end else begin
         bytes_left = len_acc;
         in_payload = 1'b1;
      end
   endtask

   task automatic check_beat();
      deframed_beat_type exp;
      logic              bad;
      if (expected_beats.size() == 0) begin
         $error("unexpected result beat: status %0d byte 0x%02h type 0x%04h last %0b",
                rsp_mon.status, rsp_mon.payload_byte, rsp_mon.frame_type,
                rsp_mon.last_of_frame);
         fail_count++;
         return;
      end
      exp = expected_beats.pop_front();
      bad = 1'b0;
      if (rsp_mon.status !== exp.status) begin
         $error("status: expected %0d, got %0d", exp.status, rsp_mon.status);
         bad = 1'b1;
      end
      if (rsp_mon.payload_byte !== exp.payload_byte) begin
         $error("payload_byte: expected 0x%02h, got 0x%02h", exp.payload_byte,
                rsp_mon.payload_byte);
         bad = 1'b1;
      end
      if (rsp_mon.frame_type !== exp.frame_type) begin
         $error("frame_type: expected 0x%04h, got 0x%04h", exp.frame_type, rsp_mon.frame_type);
         bad = 1'b1;
      end
      if (rsp_mon.last_of_frame !== exp.last_of_frame) begin
         $error("last_of_frame: expected %0b, got %0b", exp.last_of_frame,
                rsp_mon.last_of_frame);
         bad = 1'b1;
      end
      if (bad)
         fail_count++;
      case (exp.status)
         STATUS_PAYLOAD: payload_count++;
         STATUS_EMPTY:   empty_count++;
         default:        error_count++;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hdr_count       = '0;
         len_acc         = '0;
         type_acc        = '0;
         bytes_left      = '0;
         in_payload      = 1'b0;
         poisoned        = 1'b0;
         max_payload_reg = MAX_PAYLOAD_RESET;
         expected_beats.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[CSR_ADDR_W-1:2] == CSR_MAX_PAYLOAD)
                  max_payload_reg = csr_pwdata;
            end else if (csr_paddr[CSR_ADDR_W-1:2] == CSR_MAX_PAYLOAD &&
                         csr_prdata !== max_payload_reg) begin
               $error("max_payload readback: expected 0x%08h, got 0x%08h", max_payload_reg,
                      csr_prdata);
               fail_count++;
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            deframe_byte(req_mon.data_byte);
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1)
            check_beat();
      end
      pending_count = expected_beats.size();
   end

endmodule

FILE: dv/tb_length_prefixed_deframer.sv
// Top of the deframer testbench: clock, reset, byte stream, result back-pressure
// and CSR traffic. Depends on lpd_pkg, lpd_if.sv and lpd_deframe_checker.
`timescale 1ns / 100ps

module tb_length_prefixed_deframer;
   import lpd_pkg::*;

   // ~1050 random stream bytes after the directed frames
   localparam int RANDOM_BYTES     = 1050;
   localparam int PHASES           = 6;
   // receiver stall long enough to back the block up into req
   localparam int LONG_HOLD_CYCLES = 300;
   // margin after the last expected beat before touching the CSR
   localparam int DRAIN_CYCLES     = 8;
   // slowest legal run is ~0.4 ms
   localparam int TIMEOUT_NS       = 5_000_000;

   localparam logic [CSR_ADDR_W-1:0] MAX_PAYLOAD_ADDR = {CSR_MAX_PAYLOAD, 2'b00};
   // next word up, no register behind it
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR    = MAX_PAYLOAD_ADDR + CSR_ADDR_W'(4);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   int unsigned fail_count, pending_count, payload_count, empty_count, error_count;
   int unsigned bytes_sent, frames_sent, settings_used;
   bit          sender_gaps_on;
   bit          long_hold_pending;

   lpd_req_if req_ch ();
   lpd_rsp_if rsp_ch ();

   length_prefixed_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lpd_deframe_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .payload_count (payload_count),
      .empty_count   (empty_count),
      .error_count   (error_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // payload length for one frame, never above the current limit so the
   // stream stays clean until the deliberate oversize header at the end
   function automatic logic [LEN_W-1:0] pick_length(input logic [LEN_W-1:0] limit);
      logic [LEN_W-1:0] len;
      int unsigned      roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         len = $urandom_range(0, 8);
      else if (roll < 95)
         len = $urandom_range(9, 40);
      else
         len = $urandom_range(100, 300);
      if (len > limit)
         len = limit;
      // hit length == max_payload now and then
      if (limit <= 300 && $urandom_range(0, 9) == 0)
         len = limit;
      return len;
   endfunction

   // Called and returns at a falling edge. valid stays up between back-to-back
   // beats, so each step carries at most one update of it.
   task automatic send_byte(input logic [BYTE_W-1:0] data);
      int unsigned gap;
      gap = sender_gaps_on ? idle_cycles() : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      bytes_sent++;
   endtask

   // 32-bit LE length, then 16-bit LE type
   task automatic send_header(input logic [LEN_W-1:0] len, input logic [TYPE_W-1:0] ftype);
      for (int i = 0; i < LEN_BYTES; i++)
         send_byte(len[8*i +: 8]);
      send_byte(ftype[7:0]);
      send_byte(ftype[15:8]);
      frames_sent++;
   endtask

   task automatic send_frame(input logic [LEN_W-1:0] len, input logic [TYPE_W-1:0] ftype);
      send_header(len, ftype);
      for (int unsigned i = 0; i < len; i++)
         send_byte(BYTE_W'($urandom));
   endtask

   // drop valid, let every expected beat come out, then give the header
   // path its latency before anything touches the CSR
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // APB setup + access, then back to idle with psel low; the checker watches both
   // writes and readbacks
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_max_payload(input logic [LEN_W-1:0] limit);
      csr_access(1'b1, MAX_PAYLOAD_ADDR, limit);
      csr_access(1'b0, MAX_PAYLOAD_ADDR, '0);
      settings_used++;
   endtask

   // Receiver: random ready pattern, plus one long hold on request.
   // Ready is never updated twice without a falling edge in between.
   initial begin
      int unsigned on_cycles, off_cycles;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            on_cycles = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 6);
            rsp_ch.ready <= 1'b1;
            repeat (on_cycles) @(negedge clock);
            off_cycles = idle_cycles();
            if (off_cycles != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (off_cycles) @(negedge clock);
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [LEN_W-1:0] phase_limit [PHASES];
      logic [LEN_W-1:0] limit;
      int unsigned      phase_start;

      req_ch.valid      = 1'b0;
      req_ch.data_byte  = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      sender_gaps_on    = 1'b1;
      long_hold_pending = 1'b0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed: reset limit, type and byte extremes, empty frame ---
      csr_access(1'b0, MAX_PAYLOAD_ADDR, '0);      // reset value readback
      send_frame(32'd0, 16'hFFFF);                 // empty frame, all-ones type
      send_header(32'd1, 16'h0000);
      send_byte(8'hFF);                            // single-byte frame, last set
      send_header(32'd2, 16'h8001);
      send_byte(8'h00);
      send_byte(8'h7F);
      quiesce();
      // write to an unmapped word must leave max_payload alone
      csr_access(1'b1, UNMAPPED_ADDR, '0);
      csr_access(1'b0, MAX_PAYLOAD_ADDR, '0);

      // --- random phases over several limits, extremes included ---
      // zero limit: only empty frames get through
      phase_limit = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd7, $urandom_range(2, 40), $urandom};
      for (int p = 0; p < PHASES; p++) begin
         limit = phase_limit[p];
         set_max_payload(limit);
         // some phases run the sender flat out
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         if (p == 0)
            long_hold_pending = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < RANDOM_BYTES / PHASES)
            send_frame(pick_length(limit), TYPE_W'($urandom));
         quiesce();
      end

      // --- oversize length: one error beat, then everything is dropped ---
      sender_gaps_on = 1'b1;
      set_max_payload(32'hFFFF_FFFE);
      send_header(32'hFFFF_FFFF, TYPE_W'($urandom));
      repeat (12) send_byte(BYTE_W'($urandom));
      quiesce();

      $display("Covered %0d stream bytes in %0d frames under %0d max_payload settings,",
               bytes_sent, frames_sent, settings_used + 1);
      $display("ending on a poisoned stream; checked %0d payload, %0d empty, %0d error beats.",
               payload_count, empty_count, error_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
